/* sv/ubxfr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the UBX frame receiver.
// No dependencies; compile first.
package ubxfr_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;

  // Payload bytes at which a frame is dropped as too long.
  localparam int unsigned PAYLOAD_LIMIT = 1016;
  localparam int unsigned CNT_W         = $clog2(PAYLOAD_LIMIT + 1);

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned LEN_W  = 16;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_DONE    = 2'd1,
    KIND_ABORT   = 2'd2
  } kind_e;

  // Control from the frame sequencer to the checksum unit.
  typedef struct packed {
    logic clear;
    logic accumulate;
  } ck_ctrl_t;

endpackage

/* sv/ubxfr_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for received bytes and results.
// Depends on ubxfr_pkg.
interface ubxfr_rx_if import ubxfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ubxfr_res_if import ubxfr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [IDX_W-1:0]  byte_index;
  logic [BYTE_W-1:0] msg_cls;
  logic [BYTE_W-1:0] msg_id;
  logic [LEN_W-1:0]  payload_length;
  logic              checksum_ok;

  modport source (output valid, output result_kind, output payload_byte,
                  output byte_index, output msg_cls, output msg_id,
                  output payload_length, output checksum_ok, input ready);
  modport sink   (input valid, input result_kind, input payload_byte,
                  input byte_index, input msg_cls, input msg_id,
                  input payload_length, input checksum_ok, output ready);
endinterface

/* sv/ubxfr_cksum.sv */
`timescale 1ns / 1ps
// Running 8-bit Fletcher sum (A += byte, B += A) with synchronous clear.
// Depends on ubxfr_pkg.
module ubxfr_cksum import ubxfr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ck_ctrl_t          ctrl_i,
  input  logic [BYTE_W-1:0] data_i,
  output logic [BYTE_W-1:0] sum_a_o,
  output logic [BYTE_W-1:0] sum_b_o
);

  logic [BYTE_W-1:0] sum_a_q, sum_a_d;
  logic [BYTE_W-1:0] sum_b_q, sum_b_d;

  always_comb begin
    sum_a_d = sum_a_q;
    sum_b_d = sum_b_q;
    if (ctrl_i.clear) begin
      sum_a_d = '0;
      sum_b_d = '0;
    end else if (ctrl_i.accumulate) begin
      sum_a_d = sum_a_q + data_i;
      sum_b_d = sum_b_q + sum_a_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_a_q <= '0;
      sum_b_q <= '0;
    end else begin
      sum_a_q <= sum_a_d;
      sum_b_q <= sum_b_d;
    end
  end

  assign sum_a_o = sum_a_q;
  assign sum_b_o = sum_b_q;

endmodule

/* sv/ubx_frame_receiver.sv */
`timescale 1ns / 1ps
// UBX frame receiver: sync hunt, header capture, payload streaming, checksum.
// Depends on ubxfr_pkg, ubxfr_rx_if, ubxfr_res_if and ubxfr_cksum.
//
//   channel | dir | payload                                   | per request
//   --------+-----+-------------------------------------------+---------------
//   rx_i    | in  | rx_byte                                   | one byte
//   res_o   | out | result_kind, payload_byte, byte_index,    | 0 or 1 result
//           |     | msg_cls, msg_id, payload_length,          | per byte
//           |     | checksum_ok                               |
//
// One byte per cycle sustained while the result register is not stalled.
// A byte is held in the input register; the sequencer and Fletcher adders
// then update state from it and any result goes to the result register.
// rst_ni clears the sequencer to the sync hunt, the sums and all valids.
// A stalled result register freezes the input stage; one more request is
// still taken into the input register while the result waits.
module ubx_frame_receiver import ubxfr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  ubxfr_rx_if.sink    rx_i,
  ubxfr_res_if.source res_o
);

  // Sequencer phase codes
  localparam logic [3:0] PH_HUNT1   = 4'd0;
  localparam logic [3:0] PH_HUNT2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN1    = 4'd4;
  localparam logic [3:0] PH_LEN2    = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CKA     = 4'd7;
  localparam logic [3:0] PH_CKB     = 4'd8;

  // ---------------- input register ----------------
  logic              in_vld_q, in_vld_d;
  logic [BYTE_W-1:0] in_byte_q;
  logic              res_vld_q, res_vld_d;
  logic              advance;  // result register can take whatever comes
  logic              take;     // byte in input register is processed now

  assign advance    = !res_vld_q || res_o.ready;
  assign take       = in_vld_q && advance;
  assign rx_i.ready = !in_vld_q || advance;

  always_comb begin
    in_vld_d = in_vld_q;
    if (rx_i.valid && rx_i.ready) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  // ---------------- frame state ----------------
  logic [3:0]        phase_q, phase_d;
  logic [BYTE_W-1:0] held_class_q, held_class_d;
  logic [BYTE_W-1:0] held_id_q, held_id_d;
  logic [LEN_W-1:0]  held_len_q, held_len_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] ck_a_rx_q, ck_a_rx_d;

  logic [CNT_W-1:0]  count_inc;
  ck_ctrl_t          ck_ctrl;
  logic [BYTE_W-1:0] sum_a, sum_b;

  // Result produced by the byte being processed
  logic              emit;
  kind_e             emit_kind;
  logic [BYTE_W-1:0] emit_byte;
  logic [IDX_W-1:0]  emit_idx;
  logic              emit_ok;

  assign count_inc = count_q + CNT_W'(1);

  ubxfr_cksum u_cksum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ck_ctrl),
    .data_i  (in_byte_q),
    .sum_a_o (sum_a),
    .sum_b_o (sum_b)
  );

  always_comb begin
    phase_d      = phase_q;
    held_class_d = held_class_q;
    held_id_d    = held_id_q;
    held_len_d   = held_len_q;
    count_d      = count_q;
    ck_a_rx_d    = ck_a_rx_q;
    ck_ctrl      = '0;
    emit         = 1'b0;
    emit_kind    = KIND_PAYLOAD;
    emit_byte    = '0;
    emit_idx     = '0;
    emit_ok      = 1'b0;

    unique case (phase_q)
      PH_HUNT2: begin
        if (in_byte_q == SYNC_SECOND) begin
          ck_ctrl.clear = 1'b1;
          phase_d       = PH_CLASS;
        end else if (in_byte_q != SYNC_FIRST) begin
          // dropped byte is not rechecked as a first sync byte
          phase_d = PH_HUNT1;
        end
      end
      PH_CLASS: begin
        held_class_d       = in_byte_q;
        ck_ctrl.accumulate = 1'b1;
        phase_d            = PH_ID;
      end
      PH_ID: begin
        held_id_d          = in_byte_q;
        ck_ctrl.accumulate = 1'b1;
        phase_d            = PH_LEN1;
      end
      PH_LEN1: begin
        held_len_d         = {{(LEN_W-BYTE_W){1'b0}}, in_byte_q};
        ck_ctrl.accumulate = 1'b1;
        phase_d            = PH_LEN2;
      end
      PH_LEN2: begin
        held_len_d         = {in_byte_q, held_len_q[BYTE_W-1:0]};
        ck_ctrl.accumulate = 1'b1;
        count_d            = '0;
        // empty payload skips straight to the checksum
        phase_d            = (held_len_d == '0) ? PH_CKA : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        ck_ctrl.accumulate = 1'b1;
        count_d            = count_inc;
        emit               = 1'b1;
        if (count_inc >= CNT_W'(PAYLOAD_LIMIT)) begin
          emit_kind = KIND_ABORT;
          phase_d   = PH_HUNT1;
        end else begin
          emit_kind = KIND_PAYLOAD;
          emit_byte = in_byte_q;
          emit_idx  = IDX_W'(count_q);
          if (32'(count_inc) == 32'(held_len_q)) begin
            phase_d = PH_CKA;
          end
        end
      end
      PH_CKA: begin
        ck_a_rx_d = in_byte_q;
        phase_d   = PH_CKB;
      end
      PH_CKB: begin
        emit      = 1'b1;
        emit_kind = KIND_DONE;
        emit_ok   = (ck_a_rx_q == sum_a) && (in_byte_q == sum_b);
        phase_d   = PH_HUNT1;
      end
      default: begin
        // first sync hunt, also covers unused codes
        phase_d = (in_byte_q == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
      end
    endcase

    if (!take) begin
      ck_ctrl = '0;
      emit    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HUNT1;
      held_class_q <= '0;
      held_id_q    <= '0;
      held_len_q   <= '0;
      count_q      <= '0;
      ck_a_rx_q    <= '0;
    end else if (take) begin
      phase_q      <= phase_d;
      held_class_q <= held_class_d;
      held_id_q    <= held_id_d;
      held_len_q   <= held_len_d;
      count_q      <= count_d;
      ck_a_rx_q    <= ck_a_rx_d;
    end
  end

  // ---------------- result register ----------------
  kind_e             res_kind_q;
  logic [BYTE_W-1:0] res_byte_q;
  logic [IDX_W-1:0]  res_idx_q;
  logic [BYTE_W-1:0] res_class_q;
  logic [BYTE_W-1:0] res_id_q;
  logic [LEN_W-1:0]  res_len_q;
  logic              res_ok_q;

  assign res_vld_d = advance ? emit : res_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= res_vld_d;
    end
  end

  // held fields do not change on a byte that emits, so current values serve
  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_kind_q  <= emit_kind;
      res_byte_q  <= emit_byte;
      res_idx_q   <= emit_idx;
      res_class_q <= held_class_q;
      res_id_q    <= held_id_q;
      res_len_q   <= held_len_q;
      res_ok_q    <= emit_ok;
    end
  end

  assign res_o.valid          = res_vld_q;
  assign res_o.result_kind    = res_kind_q;
  assign res_o.payload_byte   = res_byte_q;
  assign res_o.byte_index     = res_idx_q;
  assign res_o.msg_cls        = res_class_q;
  assign res_o.msg_id         = res_id_q;
  assign res_o.payload_length = res_len_q;
  assign res_o.checksum_ok    = res_ok_q;

  // ---------------- assertions ----------------
  a_phase_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PH_CKB)
    else $error("sequencer phase out of range");

  a_no_empty_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> held_len_q != '0)
    else $error("payload phase entered with zero length");

  a_index_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_kind_q == KIND_PAYLOAD
      |-> 32'(res_idx_q) < 32'(PAYLOAD_LIMIT - 1) && !res_ok_q)
    else $error("payload result with bad index or checksum flag");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (phase_q == PH_CKB || phase_q == PH_PAYLOAD) |=> res_vld_q)
    else $error("emitting byte produced no result");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking bench for ubx_frame_receiver: byte stream in, results checked.
// Depends on ubxfr_pkg and ubxfr_if (ubxfr_rx_if, ubxfr_res_if) and the RTL.
module testbench;
  import ubxfr_pkg::*;

  localparam int unsigned RAND_BYTES  = 1300;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_WAIT  = 16;
  localparam int unsigned N_DIR       = 22;

  // Parser phases, mirrored for the predictor.
  typedef enum logic [3:0] {
    P_HUNT1, P_HUNT2, P_CLASS, P_ID, P_LEN1, P_LEN2, P_PAYLOAD, P_CKA, P_CKB
  } frame_ph_e;

  typedef struct packed {
    kind_e             kind;
    logic [BYTE_W-1:0] pbyte;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] cls;
    logic [BYTE_W-1:0] id;
    logic [LEN_W-1:0]  len;
    logic              ok;
  } frame_res_t;

  // One directed byte; typed rows carry a hand-written expected result.
  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              typed;
    frame_res_t        want;
  } dir_row_t;

  localparam frame_res_t NO_RES = '0;

  logic clk_i;
  logic rst_ni;

  ubxfr_rx_if  rx_ch ();
  ubxfr_res_if res_ch ();

  ubx_frame_receiver u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_ch),
    .res_o  (res_ch)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor state: frame sequencer plus Fletcher sums
  // ---------------------------------------------------------------------
  frame_ph_e         ph        = P_HUNT1;
  logic [7:0]        fl_a      = '0;
  logic [7:0]        fl_b      = '0;
  logic [7:0]        cur_class = '0;
  logic [7:0]        cur_id    = '0;
  logic [15:0]       cur_len   = '0;
  int unsigned       pay_cnt   = 0;
  logic [7:0]        ck_a_rx   = '0;

  frame_res_t        pending_results[$];
  int unsigned       fail_count = 0;
  int unsigned       bytes_sent = 0;
  int unsigned       cycle_cnt  = 0;
  bit                burst_mode = 1'b0;   // no idling on either side while set
  dir_row_t          dir_rows[N_DIR];

  function automatic void fold_sum(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endfunction

  // Advances the predictor by one byte; returns 1 when a result is due.
  function automatic bit parse_byte(input logic [7:0] b, output frame_res_t r);
    bit          emitted;
    int unsigned idx;
    emitted = 1'b0;
    r       = NO_RES;
    case (ph)
      P_HUNT2: begin
        if (b == SYNC_SECOND) begin
          fl_a = '0;
          fl_b = '0;
          ph   = P_CLASS;
        end else if (b != SYNC_FIRST) begin
          ph = P_HUNT1;          // restart; this byte is not a new first sync
        end
      end
      P_CLASS: begin
        cur_class = b;
        fold_sum(b);
        ph = P_ID;
      end
      P_ID: begin
        cur_id = b;
        fold_sum(b);
        ph = P_LEN1;
      end
      P_LEN1: begin
        cur_len = {8'h00, b};
        fold_sum(b);
        ph = P_LEN2;
      end
      P_LEN2: begin
        cur_len[15:8] = b;
        fold_sum(b);
        pay_cnt = 0;
        ph = (cur_len == 16'd0) ? P_CKA : P_PAYLOAD;
      end
      P_PAYLOAD: begin
        idx = pay_cnt;
        fold_sum(b);
        pay_cnt = idx + 1;
        if (pay_cnt >= PAYLOAD_LIMIT) begin
          r.kind = KIND_ABORT;
          ph     = P_HUNT1;
        end else begin
          r.kind  = KIND_PAYLOAD;
          r.pbyte = b;
          r.idx   = idx[IDX_W-1:0];
          if (pay_cnt == cur_len) ph = P_CKA;
        end
        emitted = 1'b1;
      end
      P_CKA: begin
        ck_a_rx = b;
        ph = P_CKB;
      end
      P_CKB: begin
        r.kind  = KIND_DONE;
        r.ok    = (ck_a_rx == fl_a) && (b == fl_b);
        ph      = P_HUNT1;
        emitted = 1'b1;
      end
      default: ph = (b == SYNC_FIRST) ? P_HUNT2 : P_HUNT1;
    endcase
    if (emitted) begin
      r.cls = cur_class;
      r.id  = cur_id;
      r.len = cur_len;
    end
    return emitted;
  endfunction

  // ---------------------------------------------------------------------
  // Byte source: random gap, then hold the request until it is taken
  // ---------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit typed, input frame_res_t want);
    frame_res_t  got;
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk_i);
    while (!rx_ch.ready) @(posedge clk_i);
    // Accepted at this edge: run the predictor now.
    if (parse_byte(b, got) && !typed) pending_results.push_back(got);
    if (typed) pending_results.push_back(want);
    bytes_sent++;
    if ($urandom_range(0, 63) == 0) burst_mode = !burst_mode;
    @(negedge clk_i);
  endtask

  // Sync, header, n_pay payload bytes; checksum only when the payload is whole and below the limit.
  task automatic send_frame(input logic [15:0] len, input int unsigned n_pay,
                            input bit bad_ck);
    logic [7:0] body[$];
    logic [7:0] sa, sb;
    logic [7:0] bit_mask;
    sa = '0;
    sb = '0;
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(8'($urandom_range(0, 255)));
    body.push_back(len[7:0]);
    body.push_back(len[15:8]);
    for (int unsigned i = 0; i < n_pay; i++) body.push_back(8'($urandom_range(0, 255)));
    foreach (body[i]) begin
      sa = sa + body[i];
      sb = sb + sa;
    end
    if ($urandom_range(0, 3) == 0) send_byte(SYNC_FIRST, 1'b0, NO_RES);  // repeated sync
    send_byte(SYNC_FIRST, 1'b0, NO_RES);
    send_byte(SYNC_SECOND, 1'b0, NO_RES);
    foreach (body[i]) send_byte(body[i], 1'b0, NO_RES);
    if (n_pay == len && len < PAYLOAD_LIMIT) begin
      if (bad_ck) begin
        bit_mask = 8'h01 << $urandom_range(0, 7);
        if ($urandom_range(0, 1)) sa = sa ^ bit_mask;
        else                      sb = sb ^ bit_mask;
      end
      send_byte(sa, 1'b0, NO_RES);
      send_byte(sb, 1'b0, NO_RES);
    end
  endtask

  // ---------------------------------------------------------------------
  // Result sink: random stall per result, with the same burst stretches
  // ---------------------------------------------------------------------
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = burst_mode ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!(res_ch.valid && res_ch.ready)) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: oldest expectation against each accepted result
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input longint unsigned want,
                                      input longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    frame_res_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation waiting: kind %0d", res_ch.result_kind);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind",    want.kind,  res_ch.result_kind);
        check_field("payload_byte",   want.pbyte, res_ch.payload_byte);
        check_field("byte_index",     want.idx,   res_ch.byte_index);
        check_field("msg_cls",        want.cls,   res_ch.msg_cls);
        check_field("msg_id",         want.id,    res_ch.msg_id);
        check_field("payload_length", want.len,   res_ch.payload_length);
        check_field("checksum_ok",    want.ok,    res_ch.checksum_ok);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    int unsigned k;
    int unsigned pick;
    int unsigned len;
    rst_ni        = 1'b0;
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = '0;
    res_ch.ready  = 1'b0;

    // Directed bytes.
    //  - repeated first sync, zero-length frame, good checksum (01 07 00 00 -> 08 19)
    //  - first sync followed by another byte restarts the hunt
    //  - all-ones class and ID, 2-byte payload, bad checksum
    //  - stray second sync byte while hunting
    dir_rows = '{
      '{8'hB5, 1'b0, NO_RES},
      '{8'hB5, 1'b0, NO_RES},
      '{8'h62, 1'b0, NO_RES},
      '{8'h01, 1'b0, NO_RES},
      '{8'h07, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{8'h08, 1'b0, NO_RES},
      '{8'h19, 1'b1, '{KIND_DONE, 8'h00, 10'd0, 8'h01, 8'h07, 16'd0, 1'b1}},
      '{8'hB5, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{8'hB5, 1'b0, NO_RES},
      '{8'h62, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'hFF, 1'b0, NO_RES},
      '{8'h02, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{8'hFF, 1'b1, '{KIND_PAYLOAD, 8'hFF, 10'd0, 8'hFF, 8'hFF, 16'd2, 1'b0}},
      '{8'h00, 1'b0, NO_RES},
      '{8'h00, 1'b0, NO_RES},
      '{8'h00, 1'b1, '{KIND_DONE, 8'h00, 10'd0, 8'hFF, 8'hFF, 16'd2, 1'b0}},
      '{8'h62, 1'b0, NO_RES}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < N_DIR; i++) send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);

    // Random part: one overlong frame first, while the parser is known to be
    // hunting, so it runs through the last legal index into the abort; then
    // mostly well-formed frames, plus noise and broken frames.
    k = 0;
    while (bytes_sent < N_DIR + RAND_BYTES) begin
      pick = $urandom_range(0, 99);
      if (k == 0) begin
        len = $urandom_range(16'hFFFF, PAYLOAD_LIMIT);
        send_frame(len[15:0], PAYLOAD_LIMIT, 1'b0);
      end else if (pick < 65) begin
        len = $urandom_range(0, 24);
        send_frame(len[15:0], len, $urandom_range(0, 4) == 0);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_RES);
      end else if (pick < 90) begin
        // first sync then something other than the second sync
        send_byte(SYNC_FIRST, 1'b0, NO_RES);
        send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)), 1'b0, NO_RES);
      end else begin
        // payload cut short: the next frame's bytes are taken as payload
        len = $urandom_range(2, 24);
        send_frame(len[15:0], $urandom_range(0, len - 1), 1'b0);
      end
      k++;
    end
    rx_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* ubx_frame_receiver.f */
sv/ubxfr_pkg.sv
sv/ubxfr_if.sv
sv/ubxfr_cksum.sv
sv/ubx_frame_receiver.sv
sim/testbench.sv
